>>> rtl/dda_pkg.sv
// shared constants, codes and types for the deferred delta accumulator
package dda_pkg;

  // field widths
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned UNIT_W   = 63;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned BUDGET_W = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // default chunk limit per apply
  localparam int unsigned MAX_CHUNKS_DEF = 64;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPLY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // accumulator modes
  localparam logic [MODE_W-1:0] MODE_SCALAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VEC3   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COUNT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BAD    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACCUM_TYPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_X     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_Y     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_Z     = 2'd3;

  // per-lane control from the sequencer
  typedef struct packed {
    logic active;  // lane takes part in the current mode
    logic clr;     // zero the owed word
    logic add;     // add the delta
    logic step;    // subtract this cycle's chunk
    logic whole;   // chunk carries the whole owed word
  } dda_lane_ctl_t;

  // per-lane status back to the merge logic
  typedef struct packed {
    logic is_zero;    // owed word is zero
    logic fits;       // owed magnitude within the unit, chunk drains it
    logic no_unit;    // configured unit is zero
  } dda_lane_sts_t;

endpackage

>>> rtl/dda_if.sv
// valid/ready channel interfaces for input items and result beats
interface dda_in_if;
  import dda_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [REQ_W-1:0]           req_type;
  logic signed [WORD_W-1:0]   delta_x;
  logic signed [WORD_W-1:0]   delta_y;
  logic signed [WORD_W-1:0]   delta_z;
  logic [CNT_W-1:0]           max_chunks;
  logic [BUDGET_W-1:0]        budget_in;

  modport source (output valid, req_type, delta_x, delta_y, delta_z, max_chunks,
                  budget_in, input ready);
  modport sink (input valid, req_type, delta_x, delta_y, delta_z, max_chunks,
                budget_in, output ready);
endinterface

interface dda_out_if;
  import dda_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       chunk_valid;
  logic signed [WORD_W-1:0]   out_x;
  logic signed [WORD_W-1:0]   out_y;
  logic signed [WORD_W-1:0]   out_z;
  logic [CNT_W-1:0]           chunks_used;
  logic [BUDGET_W-1:0]        budget_left;
  logic                       is_empty;
  logic                       last;

  modport source (output valid, chunk_valid, out_x, out_y, out_z, chunks_used,
                  budget_left, is_empty, last, input ready);
  modport sink (input valid, chunk_valid, out_x, out_y, out_z, chunks_used,
                budget_left, is_empty, last, output ready);
endinterface

>>> rtl/dda_lane.sv
// one component lane: owed word, unit register, clamp and drain
module dda_lane
  import dda_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     unit_we,
  input  logic [UNIT_W-1:0]        unit_wdata,
  input  dda_lane_ctl_t            ctl,
  input  logic [WORD_W-1:0]        delta,
  output logic [WORD_W-1:0]        chunk,
  output dda_lane_sts_t            sts
);

  logic [WORD_W-1:0] owed_r;
  logic [WORD_W-1:0] owed_nxt;
  logic [UNIT_W-1:0] unit_r;
  logic [WORD_W-1:0] unit_ext;
  logic [WORD_W-1:0] mag;
  logic [WORD_W-1:0] clamped;
  logic              neg;
  logic              fits;

  // magnitude of the owed word against the unit
  always_comb begin
    neg      = owed_r[WORD_W-1];
    unit_ext = {1'b0, unit_r};
    mag      = neg ? (WORD_W'(0) - owed_r) : owed_r;
    fits     = (mag <= unit_ext);
    clamped  = fits ? owed_r : (neg ? (WORD_W'(0) - unit_ext) : unit_ext);
    if (!ctl.active) begin
      chunk = '0;
    end else if (ctl.whole) begin
      chunk = owed_r;
    end else begin
      chunk = clamped;
    end
  end

  // owed update: clear wins over add, add over drain
  always_comb begin
    owed_nxt = owed_r;
    if (ctl.clr) begin
      owed_nxt = '0;
    end else if (ctl.add && ctl.active) begin
      owed_nxt = owed_r + delta;
    end else if (ctl.step) begin
      owed_nxt = owed_r - chunk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owed_r <= '0;
      unit_r <= '0;
    end else begin
      owed_r <= owed_nxt;
      if (unit_we) begin
        unit_r <= unit_wdata;
      end
    end
  end

  assign sts.is_zero = (owed_r == '0);
  assign sts.fits    = fits;
  assign sts.no_unit = (unit_r == '0);

endmodule

>>> rtl/deferred_delta_accumulator.sv
// top level: request sequencer, three component lanes and result merge
//
//   channel | dir | beat contents                              | accepted when
//   in_bus  | in  | req_type, deltas, max_chunks, budget_in    | valid & ready
//   out_bus | out | chunk, chunks_used, budget_left, flags     | valid & ready
//   cfg_*   | in  | register index, write data                 | cfg_we high
//
// add, clear, unknown requests and an apply with no chunks give one beat
// an apply with chunks gives no beat when accepted, then one chunk beat per cycle
// up to min(max_chunks, MAX_CHUNKS, budget_in), from a shared three-lane step
// in_bus.ready is low while an apply drains and while a beat waits unclaimed
// out_bus stalls freeze the drain; is_empty follows the owed words
// reset zeroes the owed words, units and mode at once, no clearing pass
module deferred_delta_accumulator
  import dda_pkg::*;
#(
  parameter int unsigned MAX_CHUNKS = MAX_CHUNKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [UNIT_W-1:0]    cfg_wdata,
  dda_in_if.sink               in_bus,
  dda_out_if.source            out_bus
);

  typedef enum logic {ST_IDLE, ST_APPLY} state_t;

  localparam logic [CNT_W-1:0] MC_SAT = CNT_W'(MAX_CHUNKS);

  state_t              state_r;
  logic [MODE_W-1:0]   mode_r;
  logic [CNT_W-1:0]    lim_r;
  logic [CNT_W-1:0]    used_r;
  logic [BUDGET_W-1:0] budget_r;

  logic                out_valid_r;
  logic                chunk_valid_r;
  logic [WORD_W-1:0]   out_x_r;
  logic [WORD_W-1:0]   out_y_r;
  logic [WORD_W-1:0]   out_z_r;
  logic [CNT_W-1:0]    used_out_r;
  logic [BUDGET_W-1:0] left_r;
  logic                last_r;

  dda_lane_ctl_t       ctl_x;
  dda_lane_ctl_t       ctl_yz;
  dda_lane_sts_t       sts_x;
  dda_lane_sts_t       sts_y;
  dda_lane_sts_t       sts_z;
  logic [WORD_W-1:0]   chunk_x;
  logic [WORD_W-1:0]   chunk_y;
  logic [WORD_W-1:0]   chunk_z;

  logic                slot_free;
  logic                in_fire;
  logic                step_fire;
  logic                go_apply;
  logic                beat_load;
  logic                mode_we;
  logic                is_vec;
  logic                units_zero;
  logic                empty_now;
  logic                drained;
  logic                done;
  logic [CNT_W-1:0]    mc_sat;
  logic [CNT_W-1:0]    lim_in;
  logic [CNT_W-1:0]    used_nxt;

  // handshake and request decode
  assign slot_free  = !out_valid_r || out_bus.ready;
  assign in_bus.ready = (state_r == ST_IDLE) && slot_free;
  assign in_fire    = in_bus.valid && in_bus.ready;
  assign step_fire  = (state_r == ST_APPLY) && slot_free;
  assign mode_we    = cfg_we && (cfg_idx == REG_ACCUM_TYPE);
  assign is_vec     = (mode_r == MODE_VEC3);

  // an apply with chunks to give starts the drain instead of a beat
  assign go_apply   = (in_bus.req_type == REQ_APPLY) && (lim_in != '0) && !empty_now;
  assign beat_load  = (in_fire && !go_apply) || step_fire;

  // chunk limit for a new apply
  always_comb begin
    mc_sat = (in_bus.max_chunks > MC_SAT) ? MC_SAT : in_bus.max_chunks;
    lim_in = (in_bus.budget_in < {{(BUDGET_W-CNT_W){1'b0}}, mc_sat})
           ? in_bus.budget_in[CNT_W-1:0] : mc_sat;
  end

  // merge of lane status
  always_comb begin
    units_zero = is_vec ? (sts_x.no_unit && sts_y.no_unit && sts_z.no_unit)
                        : sts_x.no_unit;
    empty_now  = (mode_r == MODE_BAD) ||
                 (sts_x.is_zero && (!is_vec || (sts_y.is_zero && sts_z.is_zero)));
    drained    = units_zero ||
                 (sts_x.fits && (!is_vec || (sts_y.fits && sts_z.fits)));
    used_nxt   = used_r + CNT_W'(1);
    done       = (used_nxt == lim_r) || drained;
  end

  // lane control
  always_comb begin
    ctl_x.active = (mode_r != MODE_BAD);
    ctl_x.clr    = mode_we || (in_fire && (in_bus.req_type == REQ_CLEAR));
    ctl_x.add    = in_fire && (in_bus.req_type == REQ_ADD);
    ctl_x.step   = step_fire;
    ctl_x.whole  = units_zero;
    ctl_yz        = ctl_x;
    ctl_yz.active = is_vec;
  end

  dda_lane u_lane_x (
    .clk        (clk),
    .rst_n      (rst_n),
    .unit_we    (cfg_we && (cfg_idx == REG_UNIT_X)),
    .unit_wdata (cfg_wdata),
    .ctl        (ctl_x),
    .delta      (in_bus.delta_x),
    .chunk      (chunk_x),
    .sts        (sts_x)
  );

  dda_lane u_lane_y (
    .clk        (clk),
    .rst_n      (rst_n),
    .unit_we    (cfg_we && (cfg_idx == REG_UNIT_Y)),
    .unit_wdata (cfg_wdata),
    .ctl        (ctl_yz),
    .delta      (in_bus.delta_y),
    .chunk      (chunk_y),
    .sts        (sts_y)
  );

  dda_lane u_lane_z (
    .clk        (clk),
    .rst_n      (rst_n),
    .unit_we    (cfg_we && (cfg_idx == REG_UNIT_Z)),
    .unit_wdata (cfg_wdata),
    .ctl        (ctl_yz),
    .delta      (in_bus.delta_z),
    .chunk      (chunk_z),
    .sts        (sts_z)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_SCALAR;
      used_r      <= '0;
      lim_r       <= '0;
    end else begin
      if (mode_we) begin
        mode_r <= cfg_wdata[MODE_W-1:0];
      end
      if (beat_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            budget_r <= in_bus.budget_in;
            lim_r    <= lim_in;
            used_r   <= '0;
            if (go_apply) begin
              state_r <= ST_APPLY;
            end else begin
              chunk_valid_r <= 1'b0;
              out_x_r       <= '0;
              out_y_r       <= '0;
              out_z_r       <= '0;
              used_out_r    <= '0;
              left_r        <= in_bus.budget_in;
              last_r        <= 1'b1;
            end
          end
        end
        ST_APPLY: begin
          if (step_fire) begin
            chunk_valid_r <= 1'b1;
            out_x_r       <= chunk_x;
            out_y_r       <= chunk_y;
            out_z_r       <= chunk_z;
            used_out_r    <= used_nxt;
            left_r        <= budget_r - {{(BUDGET_W-CNT_W){1'b0}}, used_nxt};
            last_r        <= done;
            used_r        <= used_nxt;
            if (done) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // result beat
  assign out_bus.valid       = out_valid_r;
  assign out_bus.chunk_valid = chunk_valid_r;
  assign out_bus.out_x       = out_x_r;
  assign out_bus.out_y       = out_y_r;
  assign out_bus.out_z       = out_z_r;
  assign out_bus.chunks_used = used_out_r;
  assign out_bus.budget_left = left_r;
  assign out_bus.is_empty    = empty_now;
  assign out_bus.last        = last_r;

  // a chunk beat always counts at least one chunk
  a_chunk_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && chunk_valid_r) |-> (used_out_r != '0))
    else $error("chunk beat with zero chunks_used");

  // a beat without a chunk is always a lone final beat
  a_plain_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !chunk_valid_r) |-> (last_r && (used_out_r == '0)))
    else $error("non-chunk beat not final");

  // drain never runs past its chunk limit
  a_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_APPLY) |-> ((used_r < lim_r) && (lim_r <= MC_SAT)))
    else $error("apply drain beyond chunk limit");

  // drain count and chunk output stay put while the drain is stalled
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_APPLY) && !slot_free && !mode_we) |=>
      $stable(used_r) && $stable(out_x_r))
    else $error("drain advanced under stall");

endmodule
